### design/dihedral_duplicate_detector_unit_defines.svh
// Assertion macros for the dihedral duplicate detector.
// Included by the top level; depends on nothing else.
`ifndef DIHEDRAL_DUPLICATE_DETECTOR_UNIT_DEFINES_SVH
`define DIHEDRAL_DUPLICATE_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is held.
`define DDD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define DDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDD_ASSERT(lbl, clk, rstn, prop, msg)
`define DDD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### design/ddd_pkg.sv
// Shared constants, record and token types, and the record compare function.
// Used by every module of the dihedral duplicate detector but the store; no dependencies.
`default_nettype none

package ddd_pkg;

  localparam int MAX_FLAKES = 1024;
  localparam int NUM_CELLS  = 8;
  localparam int ARMS       = 6;
  localparam int ARM_W      = 32;
  localparam int REC_W      = ARMS * ARM_W;
  localparam int DRAIN_LEN  = NUM_CELLS + 3;

  localparam int ADDR_W = $clog2(MAX_FLAKES);
  localparam int CNT_W  = $clog2(MAX_FLAKES + 1);
  localparam int IDX_W  = $clog2(MAX_FLAKES + 2 * NUM_CELLS + 1);
  localparam int SEQ_W  = $clog2(NUM_CELLS + DRAIN_LEN + 1);

  typedef logic [ARMS-1:0][ARM_W-1:0] flake_t;

  // One record moving along the chain, tagged with its store index.
  typedef struct packed {
    flake_t           rec;
    logic [IDX_W-1:0] idx;
    logic             vld;
  } tok_t;

  // True when b equals a under any rotation, taken forward or reversed.
  function automatic logic records_alike(flake_t a, flake_t b);
    logic [ARMS-1:0][ARMS-1:0] eq;
    logic fwd;
    logic rev;
    logic hit;
    int   m;
    int   n;
    for (int k = 0; k < ARMS; k++) begin
      for (int j = 0; j < ARMS; j++) begin
        eq[k][j] = (a[k] == b[j]);
      end
    end
    hit = 1'b0;
    for (int s = 0; s < ARMS; s++) begin
      fwd = 1'b1;
      rev = 1'b1;
      for (int k = 0; k < ARMS; k++) begin
        m = s + k;
        if (m >= ARMS) m = m - ARMS;
        n = s + ARMS - k;
        if (n >= ARMS) n = n - ARMS;
        fwd = fwd & eq[k][m];
        rev = rev & eq[k][n];
      end
      hit = hit | fwd | rev;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

### design/ddd_ram.sv
// Simple dual-port record store with registered read data.
// Generic; no package dependencies.
`default_nettype none

module ddd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 192,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/ddd_cell.sv
// One compare cell: holds a record and checks each passing record against it.
// Depends on ddd_pkg.
`default_nettype none

module ddd_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire ddd_pkg::tok_t held_in,
  output ddd_pkg::tok_t      held_out,
  input  wire ddd_pkg::tok_t strm_in,
  output ddd_pkg::tok_t      strm_out,
  output logic               hit
);

  import ddd_pkg::*;

  tok_t held_r;
  tok_t strm_r;
  logic hit_r;
  logic hit_nxt;

  // A passing record counts only against an earlier stored record.
  assign hit_nxt = strm_r.vld & held_r.vld & (strm_r.idx > held_r.idx) &
                   records_alike(held_r.rec, strm_r.rec);

  // Held record shifts in during a fill; the stream token moves every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r.vld <= 1'b0;
      strm_r.vld <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      if (shift_en) begin
        held_r <= held_in;
      end
      strm_r <= strm_in;
      hit_r  <= hit_nxt;
    end
  end

  assign held_out = held_r;
  assign strm_out = strm_r;
  assign hit      = hit_r;

endmodule

`default_nettype wire

### design/ddd_chain.sv
// Row of compare cells; records stream through it one cell per cycle.
// Depends on ddd_pkg and ddd_cell.
`default_nettype none

module ddd_chain (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire ddd_pkg::tok_t load_tok,
  input  wire ddd_pkg::tok_t strm_tok,
  output logic               any_hit
);

  import ddd_pkg::*;

  tok_t                 held [NUM_CELLS];
  tok_t                 strm [NUM_CELLS];
  logic [NUM_CELLS-1:0] hits;

  // Each cell takes its inputs from its left neighbor.
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    if (c == 0) begin : g_head
      ddd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .held_in  (load_tok),
        .held_out (held[c]),
        .strm_in  (strm_tok),
        .strm_out (strm[c]),
        .hit      (hits[c])
      );
    end else begin : g_body
      ddd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .held_in  (held[c-1]),
        .held_out (held[c]),
        .strm_in  (strm[c-1]),
        .strm_out (strm[c]),
        .hit      (hits[c])
      );
    end
  end

  assign any_hit = |hits;

endmodule

`default_nettype wire

### design/dihedral_duplicate_detector_unit.sv
// Top level: record loading, search sequencer, store and compare chain.
// Depends on ddd_pkg, ddd_ram, ddd_chain and the assertion macro header.
//
//   Channel | Ports                                   | Handshake
//   --------+-----------------------------------------+-----------------------------
//   input   | in_arm_0..in_arm_5, in_last_flake       | start high and busy low
//   result  | out_twins_found, out_overflow           | out_valid strobe, one cycle
//
// Records load at one per cycle while busy is low. After the last record the
// search runs in passes of 8 stored records, each with a check state, a fill
// state, a stream state over records b + 1 to n - 1 and a drain state, where n
// is the count and b the pass's first record; the single read port sets this.
// The result is strobed for one cycle; the receiver cannot stall it.
// Reset (synchronous) clears the count and flags; the store needs no clearing.
`default_nettype none
`include "dihedral_duplicate_detector_unit_defines.svh"

module dihedral_duplicate_detector_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [31:0] in_arm_0,
  input  wire logic signed [31:0] in_arm_1,
  input  wire logic signed [31:0] in_arm_2,
  input  wire logic signed [31:0] in_arm_3,
  input  wire logic signed [31:0] in_arm_4,
  input  wire logic signed [31:0] in_arm_5,
  input  wire logic        in_last_flake,
  output logic             out_valid,
  output logic             out_twins_found,
  output logic             out_overflow
);

  import ddd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_FILL   = 6'b000100,
    ST_STREAM = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_REPORT = 6'b100000
  } state_t;

  state_t           state_r,   state_nxt;
  logic [CNT_W-1:0] cnt_r,     cnt_nxt;
  logic             ovf_r,     ovf_nxt;
  logic             found_r,   found_nxt;
  logic [IDX_W-1:0] blk_r,     blk_nxt;
  logic [IDX_W-1:0] ptr_r,     ptr_nxt;
  logic [SEQ_W-1:0] seq_r,     seq_nxt;
  logic             rd_load_r, rd_load_nxt;
  logic             rd_strm_r, rd_strm_nxt;
  logic             rd_ok_r,   rd_ok_nxt;
  logic [IDX_W-1:0] rd_idx_r;

  logic             accept;
  logic             we;
  logic             re;
  flake_t           wr_rec;
  logic [REC_W-1:0] ram_rdata;
  logic [IDX_W-1:0] cnt_ext;
  logic             ptr_in_range;
  tok_t             load_tok;
  tok_t             strm_tok;
  logic             any_hit;

  assign busy         = (state_r != ST_IDLE);
  assign accept       = start & ~busy;
  assign cnt_ext      = IDX_W'(cnt_r);
  assign ptr_in_range = (ptr_r < cnt_ext);

  // Pack the incoming record.
  always_comb begin
    wr_rec[0] = in_arm_0;
    wr_rec[1] = in_arm_1;
    wr_rec[2] = in_arm_2;
    wr_rec[3] = in_arm_3;
    wr_rec[4] = in_arm_4;
    wr_rec[5] = in_arm_5;
  end

  // Record store.
  ddd_ram #(
    .DEPTH (MAX_FLAKES),
    .WIDTH (REC_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (wr_rec),
    .re    (re),
    .raddr (ptr_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Read data enters the chain either as a held record or a passing one.
  always_comb begin
    load_tok.rec = flake_t'(ram_rdata);
    load_tok.idx = rd_idx_r;
    load_tok.vld = rd_ok_r;
    strm_tok.rec = flake_t'(ram_rdata);
    strm_tok.idx = rd_idx_r;
    strm_tok.vld = rd_strm_r & rd_ok_r;
  end

  ddd_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (rd_load_r),
    .load_tok (load_tok),
    .strm_tok (strm_tok),
    .any_hit  (any_hit)
  );

  // Load and search sequencer.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    found_nxt   = found_r | any_hit;
    blk_nxt     = blk_r;
    ptr_nxt     = ptr_r;
    seq_nxt     = seq_r;
    rd_load_nxt = 1'b0;
    rd_strm_nxt = 1'b0;
    rd_ok_nxt   = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_r < CNT_W'(MAX_FLAKES)) begin
            we      = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_flake) begin
            blk_nxt   = '0;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if ((blk_r + IDX_W'(1)) >= cnt_ext) begin
          state_nxt = ST_REPORT;
        end else begin
          ptr_nxt   = blk_r;
          seq_nxt   = '0;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        rd_load_nxt = 1'b1;
        rd_ok_nxt   = ptr_in_range;
        re          = ptr_in_range;
        ptr_nxt     = ptr_r + IDX_W'(1);
        seq_nxt     = seq_r + SEQ_W'(1);
        if (seq_r == SEQ_W'(NUM_CELLS - 1)) begin
          ptr_nxt   = blk_r + IDX_W'(1);
          state_nxt = ST_STREAM;
        end
      end
      ST_STREAM: begin
        rd_strm_nxt = 1'b1;
        rd_ok_nxt   = 1'b1;
        re          = 1'b1;
        ptr_nxt     = ptr_r + IDX_W'(1);
        if ((ptr_r + IDX_W'(1)) >= cnt_ext) begin
          seq_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        seq_nxt = seq_r + SEQ_W'(1);
        if (seq_r == SEQ_W'(DRAIN_LEN - 1)) begin
          blk_nxt   = blk_r + IDX_W'(NUM_CELLS);
          state_nxt = ST_CHECK;
        end
      end
      ST_REPORT: begin
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
        found_nxt = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      found_r   <= 1'b0;
      rd_load_r <= 1'b0;
      rd_strm_r <= 1'b0;
      rd_ok_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      found_r   <= found_nxt;
      rd_load_r <= rd_load_nxt;
      rd_strm_r <= rd_strm_nxt;
      rd_ok_r   <= rd_ok_nxt;
    end
  end

  // Pointers and the index that travels with the read data.
  always_ff @(posedge clk) begin
    blk_r    <= blk_nxt;
    ptr_r    <= ptr_nxt;
    seq_r    <= seq_nxt;
    rd_idx_r <= ptr_r;
  end

  // Result transaction.
  assign out_valid       = (state_r == ST_REPORT);
  assign out_twins_found = found_r;
  assign out_overflow    = ovf_r;

  // Checks.
  `DDD_ASSERT(a_single_result, clk, rst_n, out_valid |=> !out_valid, "result repeated")
  `DDD_ASSERT(a_last_starts_search, clk, rst_n, (accept && in_last_flake) |=> busy, "no search")
  `DDD_ASSERT_ALWAYS(a_count_bound, clk, !rst_n || (cnt_r <= CNT_W'(MAX_FLAKES)), "count past capacity")
  `DDD_ASSERT(a_stream_in_range, clk, rst_n, (state_r == ST_STREAM) |-> ptr_in_range, "bad read")

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dihedral_duplicate_detector_unit.
// Depends on ddd_pkg and the top level; checks verdicts via a local predictor or table.

module tb;
  import ddd_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int TAIL_CYCLES    = 4 * DRAIN_LEN + 32;
  localparam int RANDOM_RECORDS = 550;

  localparam logic [31:0] MIN_ARM  = 32'h8000_0000;
  localparam logic [31:0] MAX_ARM  = 32'h7fff_ffff;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  typedef struct packed {
    logic twins;
    logic ovf;
  } verdict_t;

  typedef struct {
    flake_t   rec;
    bit       last;
    bit       typed;
    verdict_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_arm_0;
  logic signed [31:0] in_arm_1;
  logic signed [31:0] in_arm_2;
  logic signed [31:0] in_arm_3;
  logic signed [31:0] in_arm_4;
  logic signed [31:0] in_arm_5;
  logic               in_last_flake;
  logic               out_valid;
  logic               out_twins_found;
  logic               out_overflow;

  // Predictor state: canonical forms of the records held in the current set.
  flake_t      class_store [MAX_FLAKES];
  int unsigned held_cnt    = 0;
  bit          dropped_any = 1'b0;
  bit          twin_hit    = 1'b0;

  verdict_t verdict_q [$];
  flake_t   set_q [$];
  dir_row_t dir_rows [$];

  int err_cnt      = 0;
  int idle_cycles  = 0;
  int records_sent = 0;
  int sets_done    = 0;
  int twin_sets    = 0;
  int ovf_sets     = 0;

  dihedral_duplicate_detector_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_arm_0        (in_arm_0),
    .in_arm_1        (in_arm_1),
    .in_arm_2        (in_arm_2),
    .in_arm_3        (in_arm_3),
    .in_arm_4        (in_arm_4),
    .in_arm_5        (in_arm_5),
    .in_last_flake   (in_last_flake),
    .out_valid       (out_valid),
    .out_twins_found (out_twins_found),
    .out_overflow    (out_overflow)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Builds a record with element 0 first.
  function automatic flake_t flake(input logic [31:0] a0, input logic [31:0] a1,
                                   input logic [31:0] a2, input logic [31:0] a3,
                                   input logic [31:0] a4, input logic [31:0] a5);
    flake_t f;
    f[0] = a0;
    f[1] = a1;
    f[2] = a2;
    f[3] = a3;
    f[4] = a4;
    f[5] = a5;
    return f;
  endfunction

  // Rotates a record by the given shift, optionally reading it backwards.
  function automatic flake_t align(input flake_t r, input int shift, input bit rev);
    flake_t t;
    for (int k = 0; k < ARMS; k++) begin
      t[k] = rev ? r[(shift + ARMS - k) % ARMS] : r[(shift + k) % ARMS];
    end
    return t;
  endfunction

  // The smallest of the twelve alignments; alike records share it.
  function automatic flake_t canonical(input flake_t r);
    flake_t best;
    flake_t cand;
    best = r;
    for (int s = 0; s < ARMS; s++) begin
      for (int d = 0; d < 2; d++) begin
        cand = align(r, s, d[0]);
        if (cand < best) best = cand;
      end
    end
    return best;
  endfunction

  // Folds one accepted record into the predictor; returns 1 when a verdict is due.
  function automatic bit absorb_flake(input flake_t r, input bit last, output verdict_t v);
    flake_t key;
    v = '0;
    if (held_cnt < MAX_FLAKES) begin
      key = canonical(r);
      for (int i = 0; i < held_cnt; i++) begin
        if (class_store[i] == key) twin_hit = 1'b1;
      end
      class_store[held_cnt] = key;
      held_cnt++;
    end else begin
      dropped_any = 1'b1;
    end
    if (!last) return 1'b0;
    v.twins     = twin_hit;
    v.ovf       = dropped_any;
    held_cnt    = 0;
    dropped_any = 1'b0;
    twin_hit    = 1'b0;
    return 1'b1;
  endfunction

  // Element values biased toward small numbers and the extremes.
  function automatic logic [31:0] random_arm();
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(0, 3);
      2: return MIN_ARM;
      3: return MAX_ARM;
      4: return ALL_ONES;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_row(input flake_t r, input int last, input int typed,
                         input int tw, input int ov);
    dir_row_t row;
    row.rec        = r;
    row.last       = (last != 0);
    row.typed      = (typed != 0);
    row.want.twins = (tw != 0);
    row.want.ovf   = (ov != 0);
    dir_rows.push_back(row);
  endtask

  // Sends one record after an optional idle gap; queues the given or predicted verdict.
  task automatic send_flake(input flake_t r, input bit last, input int gap,
                            input bit typed, input verdict_t want);
    verdict_t v;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_arm_0      <= r[0];
    in_arm_1      <= r[1];
    in_arm_2      <= r[2];
    in_arm_3      <= r[3];
    in_arm_4      <= r[4];
    in_arm_5      <= r[5];
    in_last_flake <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    records_sent++;
    if (absorb_flake(r, last, v)) verdict_q.push_back(typed ? want : v);
  endtask

  // Sends the queued set, marking its final record as last.
  task automatic drive_set(input bit burst);
    int gap;
    for (int j = 0; j < set_q.size(); j++) begin
      gap = burst ? 0 : $urandom_range(0, 10);
      send_flake(set_q[j], j == set_q.size() - 1, gap, 1'b0, '0);
    end
    set_q.delete();
  endtask

  // A random set in which some records are alignments of earlier ones,
  // some of them with one bit flipped to make a near miss.
  task automatic build_random_set(input int size);
    flake_t r;
    int     a;
    int     b;
    for (int j = 0; j < size; j++) begin
      if (j > 0 && $urandom_range(0, 3) == 0) begin
        r = align(set_q[$urandom_range(0, j - 1)], $urandom_range(0, 5),
                  $urandom_range(0, 1) == 1);
        if ($urandom_range(0, 2) == 0) begin
          a = $urandom_range(0, ARMS - 1);
          b = $urandom_range(0, ARM_W - 1);
          r[a][b] = ~r[a][b];
        end
      end else begin
        r = flake(random_arm(), random_arm(), random_arm(),
                  random_arm(), random_arm(), random_arm());
      end
      set_q.push_back(r);
    end
  endtask

  // Fills the store with fully random records.
  task automatic build_full_random(input int size);
    for (int j = 0; j < size; j++) begin
      set_q.push_back(flake($urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom()));
    end
  endtask

  // Reset, each accepted cycle and each result reset the watchdog's idle count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Compares each result transaction with the oldest expected verdict.
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        $error("Unexpected result: twins_found=%0b overflow=%0b",
               out_twins_found, out_overflow);
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (out_twins_found !== want.twins) begin
          $error("twins_found mismatch: expected %0b, got %0b", want.twins, out_twins_found);
          err_cnt++;
        end
        if (out_overflow !== want.ovf) begin
          $error("overflow mismatch: expected %0b, got %0b", want.ovf, out_overflow);
          err_cnt++;
        end
        sets_done++;
        if (out_twins_found === 1'b1) twin_sets++;
        if (out_overflow === 1'b1) ovf_sets++;
      end
    end
  end

  // Stimulus: directed sets, two sets at the store's capacity, then random sets.
  initial begin
    int n;
    int size;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_arm_0      <= '0;
    in_arm_1      <= '0;
    in_arm_2      <= '0;
    in_arm_3      <= '0;
    in_arm_4      <= '0;
    in_arm_5      <= '0;
    in_last_flake <= 1'b0;

    // A lone record has no partner.
    add_row(flake(1, 2, 3, 4, 5, 6), 1, 1, 0, 0);
    // Extreme values, second record rotated forward.
    add_row(flake(MIN_ARM, MAX_ARM, 0, ALL_ONES, 1, 32'hffff_fffe), 0, 0, 0, 0);
    add_row(flake(0, ALL_ONES, 1, 32'hffff_fffe, MIN_ARM, MAX_ARM), 1, 1, 1, 0);
    // Mirror image.
    add_row(flake(1, 2, 3, 4, 5, 6), 0, 0, 0, 0);
    add_row(flake(6, 5, 4, 3, 2, 1), 1, 1, 1, 0);
    // Near misses: one element changed, two neighbors swapped.
    add_row(flake(1, 2, 3, 4, 5, 6), 0, 0, 0, 0);
    add_row(flake(1, 2, 3, 4, 5, 7), 0, 0, 0, 0);
    add_row(flake(2, 1, 3, 4, 5, 6), 0, 0, 0, 0);
    add_row(flake(1, 3, 2, 4, 5, 6), 1, 0, 0, 0);
    // Uniform records of distinct values.
    add_row(flake(0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
    add_row(flake(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES), 0, 0, 0, 0);
    add_row(flake(MAX_ARM, MAX_ARM, MAX_ARM, MAX_ARM, MAX_ARM, MAX_ARM), 0, 0, 0, 0);
    add_row(flake(MIN_ARM, MIN_ARM, MIN_ARM, MIN_ARM, MIN_ARM, MIN_ARM), 1, 1, 0, 0);
    // Identical uniform records.
    add_row(flake(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES), 0, 0, 0, 0);
    add_row(flake(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES), 1, 1, 1, 0);
    // Twins with a stranger in between.
    add_row(flake(MIN_ARM, 0, 0, 0, 0, 0), 0, 0, 0, 0);
    add_row(flake(0, 0, 0, 0, 0, MAX_ARM), 0, 0, 0, 0);
    add_row(flake(0, 0, MIN_ARM, 0, 0, 0), 1, 0, 0, 0);
    // Reversed twin, not adjacent.
    add_row(flake(10, 20, 30, 40, 50, 60), 0, 0, 0, 0);
    add_row(flake(11, 20, 30, 40, 50, 60), 0, 0, 0, 0);
    add_row(flake(40, 30, 20, 10, 60, 50), 1, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_flake(dir_rows[i].rec, dir_rows[i].last, $urandom_range(0, 10),
                 dir_rows[i].typed, dir_rows[i].want);
    end

    // Store full: one dropped record, then a dropped last record that
    // matches a stored one and therefore must not count.
    build_full_random(MAX_FLAKES);
    set_q.push_back(align(set_q[3], 1, 0));
    set_q.push_back(align(set_q[0], 2, 1));
    drive_set(1'b0);

    // Exactly full: the final stored record twins an early one.
    build_full_random(MAX_FLAKES - 1);
    set_q.push_back(align(set_q[100], 5, 0));
    drive_set($urandom_range(0, 1) == 1);

    // Random sets, mostly short, some with back-to-back transactions.
    n = 0;
    while (n < RANDOM_RECORDS) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      build_random_set(size);
      n += size;
      drive_set($urandom_range(0, 3) == 0);
    end
    start <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d records in %0d sets, including two sets at full capacity.",
             records_sent, sets_done);
    $display("%0d sets reported twins and %0d reported overflow.", twin_sets, ovf_sets);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### dihedral_duplicate_detector_unit.f
+incdir+design
design/ddd_pkg.sv
design/ddd_ram.sv
design/ddd_cell.sv
design/ddd_chain.sv
design/dihedral_duplicate_detector_unit.sv
verif/tb.sv
